// ===== sv/sspwm_pkg.sv =====
package sspwm_pkg;

	localparam int unsigned NUM_SERVOS = 4;
	localparam int unsigned ANGLE_W    = 9;
	localparam int unsigned PERIOD_W   = 8;
	localparam int unsigned GAIN_W     = 22;
	localparam int unsigned OFFSET_W   = 14;
	localparam int unsigned CMP_W      = 16;

	localparam logic [ANGLE_W-1:0]  RST_MAX_FIRST = 9'd301;
	localparam logic [ANGLE_W-1:0]  RST_MAX_REST  = 9'd180;
	localparam logic [GAIN_W-1:0]   RST_GAIN      = 22'd2184533;
	localparam logic [OFFSET_W-1:0] RST_OFFSET    = 14'd1500;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_MOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MAX_FIRST = 2'd0,
		REG_MAX_REST  = 2'd1,
		REG_GAIN      = 2'd2,
		REG_OFFSET    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]  max_first;
		logic [ANGLE_W-1:0]  max_rest;
		logic [GAIN_W-1:0]   gain;
		logic [OFFSET_W-1:0] offset;
	} cfg_t;

	typedef struct packed {
		logic                tick;
		logic                move;
		logic [ANGLE_W-1:0]  goal;
		logic [PERIOD_W-1:0] period;
	} chan_cmd_t;

	function automatic logic [ANGLE_W-1:0] start_angle(input logic [1:0] ch);
		logic [ANGLE_W-1:0] a;
		case (ch)
			2'd0:    a = 9'd59;
			2'd1:    a = 9'd59;
			2'd2:    a = 9'd178;
			2'd3:    a = 9'd41;
			default: a = 9'd59;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/servo_slew_ramp_pwm_unit.sv =====
// Four-channel servo slew limiter. Each input transaction is either a tick
// (tuser = 0) or a move request (tuser = 1) for one servo; every transaction
// yields exactly one result carrying the four PWM compare values and the
// moving mask as they stand after that transaction. One transaction is
// accepted per clock while s_tready is high. It sits in the input
// register; the per-channel state update and the 9x22 compare multiply
// then load the result register, which drives m_tvalid. While a result
// waits for m_tready the input register can still take one more
// transaction, then s_tready drops. The user writes registers over the
// APB port only while no transaction is in flight; the block does not enforce it.
module servo_slew_ramp_pwm_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // servo_index[1:0], target_angle[10:2], step_ms[18:11]
	input  logic        s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // compare_one[15:0], compare_two[31:16],
	                              // compare_three[47:32], compare_four[63:48],
	                              // moving_mask[67:64]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sspwm_pkg::cfg_t      cfg;
	sspwm_pkg::chan_cmd_t ch_cmd [4];

	logic        valid_s1;
	logic        cmd_s1;
	logic [1:0]  idx_s1;
	logic [8:0]  tgt_s1;
	logic [7:0]  step_s1;
	logic        adv;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [15:0] cmp [4];
	logic [3:0]  mask;

	sspwm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			idx_s1  <= s_tdata[1:0];
			tgt_s1  <= s_tdata[10:2];
			step_s1 <= s_tdata[18:11];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_ch
		localparam logic [1:0] CH = 2'(i);

		always_comb begin
			ch_cmd[i].tick   = adv && (cmd_s1 == sspwm_pkg::CMD_TICK);
			ch_cmd[i].move   = adv && (cmd_s1 == sspwm_pkg::CMD_MOVE) && (idx_s1 == CH);
			ch_cmd[i].goal   = tgt_s1;
			ch_cmd[i].period = step_s1;
		end

		sspwm_channel #(.CH(CH)) u_ch (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (ch_cmd[i]),
			.limit   ((i == 0) ? cfg.max_first : cfg.max_rest),
			.gain    (cfg.gain),
			.offset  (cfg.offset),
			.compare (cmp[i]),
			.moving  (mask[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// channel state and result register load on the same edge, so the
	// result is built from the channels' next values
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {4'd0, mask, cmp[3], cmp[2], cmp[1], cmp[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== sv/sspwm_regs.sv =====
module sspwm_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output sspwm_pkg::cfg_t     cfg
);

	sspwm_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_first <= sspwm_pkg::RST_MAX_FIRST;
			cfg_q.max_rest  <= sspwm_pkg::RST_MAX_REST;
			cfg_q.gain      <= sspwm_pkg::RST_GAIN;
			cfg_q.offset    <= sspwm_pkg::RST_OFFSET;
		end else if (wr_en) begin
			case (idx)
				sspwm_pkg::REG_MAX_FIRST: cfg_q.max_first <= pwdata[8:0];
				sspwm_pkg::REG_MAX_REST:  cfg_q.max_rest  <= pwdata[8:0];
				sspwm_pkg::REG_GAIN:      cfg_q.gain      <= pwdata[21:0];
				sspwm_pkg::REG_OFFSET:    cfg_q.offset    <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sspwm_pkg::REG_MAX_FIRST: prdata = {23'd0, cfg_q.max_first};
			sspwm_pkg::REG_MAX_REST:  prdata = {23'd0, cfg_q.max_rest};
			sspwm_pkg::REG_GAIN:      prdata = {10'd0, cfg_q.gain};
			sspwm_pkg::REG_OFFSET:    prdata = {18'd0, cfg_q.offset};
			default:                  prdata = 32'd0;
		endcase
	end

endmodule

// ===== sv/sspwm_channel.sv =====
module sspwm_channel #(
	parameter logic [1:0] CH = 2'd0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sspwm_pkg::chan_cmd_t  cmd,
	input  logic [8:0]            limit,
	input  logic [21:0]           gain,
	input  logic [13:0]           offset,
	output logic [15:0]           compare,
	output logic                  moving
);

	logic [8:0]  angle_q, goal_q, angle_n, goal_n, step_angle;
	logic [7:0]  period_q, wait_q, period_n, wait_n, wait_inc;
	logic [15:0] compare_q, compare_n, sat;
	logic        do_step;
	logic [30:0] prod;
	logic [31:0] rounded;
	logic [16:0] sum;

	always_comb begin
		goal_n   = goal_q;
		period_n = period_q;
		wait_n   = wait_q;
		do_step  = 1'b0;
		wait_inc = wait_q + 8'd1;
		if (cmd.move) begin
			goal_n   = cmd.goal;
			period_n = cmd.period;
			wait_n   = 8'd0;
			do_step  = (angle_q != cmd.goal);
		end else if (cmd.tick && (angle_q != goal_q)) begin
			if (wait_inc >= period_q) begin
				wait_n  = 8'd0;
				do_step = 1'b1;
			end else begin
				wait_n = wait_inc;
			end
		end
	end

	assign step_angle = (angle_q < goal_n) ? angle_q + 9'd1 : angle_q - 9'd1;

	// round to nearest, halves up, then saturate
	assign prod    = 31'(step_angle) * 31'(gain);
	assign rounded = {1'b0, prod} + 32'd32768;
	assign sum     = {1'b0, rounded[31:16]} + 17'(offset);
	assign sat     = sum[16] ? 16'hFFFF : sum[15:0];

	assign angle_n   = do_step ? step_angle : angle_q;
	assign compare_n = (do_step && (step_angle <= limit)) ? sat : compare_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q   <= sspwm_pkg::start_angle(CH);
			goal_q    <= sspwm_pkg::start_angle(CH);
			period_q  <= 8'd0;
			wait_q    <= 8'd0;
			compare_q <= 16'd0;
		end else begin
			angle_q   <= angle_n;
			goal_q    <= goal_n;
			period_q  <= period_n;
			wait_q    <= wait_n;
			compare_q <= compare_n;
		end
	end

	// state as it stands after this cycle's update
	assign compare = compare_n;
	assign moving  = (angle_n != goal_n);

endmodule
